// ===== rtl/rfsfb_pkg.sv =====
`timescale 1ns / 1ps
package rfsfb_pkg;

    localparam int CMD_W   = 2;
    localparam int COORD_W = 8;
    localparam int SIZE_W  = 9;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int DIM_W   = 9;
    localparam int ZOOM_W  = 5;
    localparam int PROD_W  = 15;
    localparam int IDX_W   = 18;
    localparam int DIFF_W  = 10;
    localparam int SAD_W   = 26;
    localparam int REG_W   = 9;
    localparam int REGI_W  = 2;

    localparam logic [SAD_W-1:0] SAD_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_FILL    = 2'd1,
        CMD_COMPARE = 2'd2
    } cmd_t;

    typedef enum logic [REGI_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_ZOOM         = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FILL_MUL,
        ST_FILL_CLIP,
        ST_FILL_RUN
    } state_t;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [DIFF_W-1:0] pixel_sad(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
        return DIFF_W'(abs_diff(a[23:16], b[23:16]))
             + DIFF_W'(abs_diff(a[15:8], b[15:8]))
             + DIFF_W'(abs_diff(a[7:0], b[7:0]));
    endfunction

endpackage

// ===== rtl/rfsfb_ram.sv =====
`timescale 1ns / 1ps
module rfsfb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rect_fill_sad_framebuffer.sv =====
`timescale 1ns / 1ps
// Frame buffer engine that paints a candidate RGB picture and scores it against a target.
// Commands arrive as beats on the s_ channel: clear paints the whole store, fill paints a
// rectangle scaled by zoom and clipped at the right and bottom frame edges, and compare
// takes one target pixel in raster order. The cfg_ channel writes frame_width (index 0),
// frame_height (index 1) and zoom (index 2); it is always ready, and is to be written only
// while idle, which the block itself does not enforce. A clear writes each pixel address in
// turn; a fill passes a multiply and a clip state, then writes each covered pixel in turn;
// both are bound by the single write port of the pixel memory. Compare beats stream at one
// per cycle when idle and unstalled, via a memory read stage that feeds frame totals to m_.
// The total sits in an output register, so draw and compare beats keep flowing while it
// waits. Only a frame-completing compare that finds the previous total still untaken holds
// the read stage, and the input stalls until the receiver takes that total.
// After reset the configuration returns to 256 by 256 with zoom 1 and the compare position
// and running sum are zero; the pixel memory holds no defined content until written.
module rect_fill_sad_framebuffer #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rfsfb_pkg::REGI_W-1:0]    cfg_index,
    input  logic [rfsfb_pkg::REG_W-1:0]     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rfsfb_pkg::CMD_W-1:0]     s_command,
    input  logic [rfsfb_pkg::COORD_W-1:0]   s_rect_x,
    input  logic [rfsfb_pkg::COORD_W-1:0]   s_rect_y,
    input  logic [rfsfb_pkg::SIZE_W-1:0]    s_rect_w,
    input  logic [rfsfb_pkg::SIZE_W-1:0]    s_rect_h,
    input  logic [rfsfb_pkg::CHAN_W-1:0]    s_red,
    input  logic [rfsfb_pkg::CHAN_W-1:0]    s_green,
    input  logic [rfsfb_pkg::CHAN_W-1:0]    s_blue,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rfsfb_pkg::SAD_W-1:0]     m_sad_total
);
    import rfsfb_pkg::*;

    localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(PIXELS - 1);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]  frame_width_reg, frame_height_reg;
    logic [ZOOM_W-1:0] zoom_reg;
    logic [DIM_W-1:0]  fw, fh;
    logic [IDX_W-1:0]  total;

    logic [COORD_W-1:0] rx_reg, ry_reg;
    logic [SIZE_W-1:0]  rw_reg, rh_reg;
    logic [PIX_W-1:0]   color_reg;
    logic [PROD_W-1:0]  x0_reg, y0_reg, x1_reg, y1_reg;
    logic [DIM_W-1:0]   x0c_reg, x1c_reg, y1c_reg, x1c, y1c;
    logic               fill_empty;
    logic [DIM_W-1:0]   px_reg, px_next, py_reg, py_next;
    logic [IDX_W-1:0]   row_base_reg, row_base_next, fill_sum;
    logic               last_col, last_row;

    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic              s_accept, cmp_accept, cmp_last;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              cmp_v_reg, cmp_v_next, cmp_last_reg;
    logic [PIX_W-1:0]  tgt_reg;
    logic              cmp_stall, cmp_adv;
    logic [SAD_W-1:0]  acc_reg, acc_next, acc_sat;
    logic [SAD_W:0]    acc_sum;
    logic              m_valid_reg, m_valid_next;
    logic [SAD_W-1:0]  m_total_reg;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [PIX_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= DIM_W'(256);
            frame_height_reg <= DIM_W'(256);
            zoom_reg         <= ZOOM_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_ZOOM:         zoom_reg         <= cfg_data[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg == '0) begin
            fw = DIM_W'(1);
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            fw = DIM_W'(MAX_WIDTH);
        end else begin
            fw = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            fh = DIM_W'(1);
        end else if (32'(frame_height_reg) > MAX_HEIGHT) begin
            fh = DIM_W'(MAX_HEIGHT);
        end else begin
            fh = frame_height_reg;
        end
        total = IDX_W'(fw) * IDX_W'(fh);
    end

    assign s_accept   = s_valid && s_ready;
    assign cmp_accept = s_accept && (s_command == CMD_COMPARE);
    assign cmp_stall  = cmp_v_reg && cmp_last_reg && m_valid_reg && !m_ready;
    assign cmp_adv    = cmp_v_reg && !cmp_stall;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_command)
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_FILL:  state_next = ST_FILL_MUL;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL_MUL:  state_next = ST_FILL_CLIP;
            ST_FILL_CLIP: state_next = fill_empty ? ST_IDLE : ST_FILL_RUN;
            ST_FILL_RUN: begin
                if (last_col && last_row) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        unique case (state_reg)
            ST_IDLE:      s_ready = !cmp_stall;
            ST_CLEAR:     ram_we  = 1'b1;
            ST_FILL_MUL:  ;
            ST_FILL_CLIP: ;
            ST_FILL_RUN: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(fill_sum);
            end
            default: ;
        endcase
    end

    always_comb begin
        x1c        = (x1_reg > PROD_W'(fw)) ? fw : DIM_W'(x1_reg);
        y1c        = (y1_reg > PROD_W'(fh)) ? fh : DIM_W'(y1_reg);
        fill_empty = (x0_reg >= PROD_W'(x1c)) || (y0_reg >= PROD_W'(y1c));
        fill_sum   = row_base_reg + IDX_W'(px_reg);
        last_col   = (DIM_W'(px_reg + 1'b1) == x1c_reg);
        last_row   = (DIM_W'(py_reg + 1'b1) == y1c_reg);

        px_next       = px_reg;
        py_next       = py_reg;
        row_base_next = row_base_reg;
        if (state_reg == ST_FILL_CLIP) begin
            px_next       = DIM_W'(x0_reg);
            py_next       = DIM_W'(y0_reg);
            row_base_next = IDX_W'(DIM_W'(y0_reg)) * IDX_W'(fw);
        end else if (state_reg == ST_FILL_RUN) begin
            if (last_col) begin
                px_next       = x0c_reg;
                py_next       = DIM_W'(py_reg + 1'b1);
                row_base_next = row_base_reg + IDX_W'(fw);
            end else begin
                px_next = DIM_W'(px_reg + 1'b1);
            end
        end

        clr_addr_next = (state_reg == ST_CLEAR) ? AW'(clr_addr_reg + 1'b1) : '0;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_accept) begin
            rx_reg    <= s_rect_x;
            ry_reg    <= s_rect_y;
            rw_reg    <= s_rect_w;
            rh_reg    <= s_rect_h;
            color_reg <= {s_red, s_green, s_blue};
        end
        if (state_reg == ST_FILL_MUL) begin
            x0_reg <= PROD_W'(rx_reg) * PROD_W'(zoom_reg);
            y0_reg <= PROD_W'(ry_reg) * PROD_W'(zoom_reg);
            x1_reg <= (PROD_W'(rx_reg) + PROD_W'(rw_reg)) * PROD_W'(zoom_reg);
            y1_reg <= (PROD_W'(ry_reg) + PROD_W'(rh_reg)) * PROD_W'(zoom_reg);
        end
        if (state_reg == ST_FILL_CLIP) begin
            x0c_reg <= DIM_W'(x0_reg);
            x1c_reg <= x1c;
            y1c_reg <= y1c;
        end
        px_reg       <= px_next;
        py_reg       <= py_next;
        row_base_reg <= row_base_next;
        if (cmp_accept) begin
            tgt_reg      <= {s_red, s_green, s_blue};
            cmp_last_reg <= cmp_last;
        end
        if (cmp_adv && cmp_last_reg) begin
            m_total_reg <= acc_sat;
        end
    end

    always_comb begin
        cmp_last     = (32'(cmp_idx_reg) + 32'd1) >= 32'(total);
        cmp_idx_next = cmp_idx_reg;
        if (cmp_accept) begin
            cmp_idx_next = cmp_last ? '0 : AW'(cmp_idx_reg + 1'b1);
        end

        cmp_v_next = cmp_accept || cmp_stall;

        acc_sum = {1'b0, acc_reg} + (SAD_W + 1)'(pixel_sad(ram_rdata, tgt_reg));
        acc_sat = acc_sum[SAD_W] ? SAD_MAX : acc_sum[SAD_W-1:0];
        acc_next = acc_reg;
        if (cmp_adv) begin
            acc_next = cmp_last_reg ? '0 : acc_sat;
        end

        m_valid_next = m_valid_reg && !m_ready;
        if (cmp_adv && cmp_last_reg) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            clr_addr_reg <= '0;
            cmp_idx_reg  <= '0;
            cmp_v_reg    <= 1'b0;
            acc_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cmp_idx_reg  <= cmp_idx_next;
            cmp_v_reg    <= cmp_v_next;
            acc_reg      <= acc_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_sad_total = m_total_reg;

    rfsfb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIXELS),
        .AW    (AW)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (color_reg),
        .re    (cmp_accept),
        .raddr (cmp_idx_reg),
        .rdata (ram_rdata)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_accept |-> !ram_we)
        else $error("Compare read collides with a pixel write.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmp_accept && cmp_last) |=> (cmp_idx_reg == '0))
        else $error("Compare position did not wrap at the end of a frame.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmp_adv && cmp_last_reg) |=> m_valid_reg)
        else $error("Frame total was dropped.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL_RUN) |-> (fill_sum < total))
        else $error("Fill address lies outside the active frame.");

endmodule
